@@ rtl/cal_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and controller/datapath handshake types for the compacting array list.
// Depends on nothing; imported by every module of the block.
package cal_pkg;

	// Request action codes.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       write_insert;
		logic       start_shift;
		logic       start_scan;
		logic       issue_shift;
		logic       issue_scan;
		logic       dec_fill;
		logic       capture_pos;
		logic       load_result;
		logic [1:0] res_status;
	} cal_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] act;
		logic       full;
		logic       bad_index;
		logic       shift_more;
		logic       scan_more;
		logic       valid_s1;
		logic       hit;
	} cal_sts_t;

endpackage

@@ rtl/cal_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the compacting array list.
// Depends on cal_pkg for codes and the command and status structs.
module cal_ctrl
	import cal_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  cal_sts_t sts,
	output cal_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] res_q;
	logic [1:0] res_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.act)
					ACT_INSERT: begin
						if (sts.full) begin
							res_d = ST_FULL;
						end else begin
							cmd.write_insert = 1'b1;
							res_d            = ST_OK;
						end
						state_d = S_FINISH;
					end
					ACT_REMOVE: begin
						if (sts.bad_index) begin
							res_d   = ST_BAD_INDEX;
							state_d = S_FINISH;
						end else begin
							cmd.start_shift = 1'b1;
							state_d         = S_SHIFT;
						end
					end
					ACT_SEARCH: begin
						cmd.start_scan = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						res_d   = ST_OK;
						state_d = S_FINISH;
					end
				endcase
			end
			S_SHIFT: begin
				// Move one entry down per cycle until the tail is reached.
				cmd.issue_shift = sts.shift_more;
				if (!sts.shift_more && !sts.valid_s1) begin
					cmd.dec_fill = 1'b1;
					res_d        = ST_OK;
					state_d      = S_FINISH;
				end
			end
			S_SCAN: begin
				// Compare one entry per cycle; stop at the first match.
				if (sts.hit) begin
					cmd.capture_pos = 1'b1;
					res_d           = ST_OK;
					state_d         = S_FINISH;
				end else begin
					cmd.issue_scan = sts.scan_more;
					if (!sts.scan_more && !sts.valid_s1) begin
						res_d   = ST_NOT_FOUND;
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, pending status and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/cal_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the compacting array list: request registers, entry memory,
// fill count, walk pointer and result registers. Depends on cal_pkg.
module cal_dp
	import cal_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic [3:0]         index,
	input  cal_cmd_t           cmd,
	output cal_sts_t           sts,
	output logic [1:0]         status,
	output logic [3:0]         position,
	output logic [4:0]         count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]        mem [CAPACITY];
	logic [1:0]         act_q;
	logic signed [31:0] value_q;
	logic [3:0]         index_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      ptr_q;
	logic [CW:0]        ptr_inc;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic               wr_en;
	logic               valid_s1;
	logic               wr_s1;
	logic [AW-1:0]      addr_s1;
	logic [31:0]        rdata_s1;
	logic [AW-1:0]      pos_q;
	logic [CW+3:0]      idx_ext;
	logic [CW+3:0]      fill_ext;
	logic [AW+3:0]      pos_ext;
	logic [CW+4:0]      cnt_ext;
	logic [1:0]         status_q;
	logic [3:0]         position_q;
	logic [4:0]         count_q;

	// Walk pointer arithmetic and range checks.
	assign ptr_inc  = {1'b0, ptr_q} + (CW + 1)'(1);
	assign idx_ext  = {{CW{1'b0}}, index_q};
	assign fill_ext = {4'b0000, fill_q};
	assign rd_addr  = cmd.issue_shift ? ptr_inc[AW-1:0] : ptr_q[AW-1:0];

	assign sts.act        = act_q;
	assign sts.full       = (fill_q == CW'(CAPACITY));
	assign sts.bad_index  = (idx_ext >= fill_ext);
	assign sts.shift_more = (ptr_inc < {1'b0, fill_q});
	assign sts.scan_more  = (ptr_q < fill_q);
	assign sts.valid_s1   = valid_s1;
	assign sts.hit        = valid_s1 && !wr_s1 && (rdata_s1 == value_q);

	// Single write port: an append or the write half of a shift step.
	assign wr_en   = cmd.write_insert || (valid_s1 && wr_s1);
	assign wr_addr = cmd.write_insert ? fill_q[AW-1:0] : addr_s1;
	assign wr_data = cmd.write_insert ? value_q : rdata_s1;

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Request capture and result payload.
	assign pos_ext = {4'b0000, pos_q};
	assign cnt_ext = {5'b00000, fill_q};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q   <= action;
			value_q <= value;
			index_q <= index;
		end
		if (cmd.load_result) begin
			status_q   <= cmd.res_status;
			position_q <= pos_ext[3:0];
			count_q    <= cnt_ext[4:0];
		end
		if (cmd.issue_shift || cmd.issue_scan) begin
			addr_s1 <= cmd.issue_shift ? ptr_q[AW-1:0] : rd_addr;
		end
		wr_s1 <= cmd.issue_shift;
	end

	// Fill count, walk pointer, read stage valid and match position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			valid_s1 <= cmd.issue_shift || cmd.issue_scan;
			if (cmd.write_insert) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.dec_fill) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.start_shift) begin
				ptr_q <= idx_ext[CW-1:0];
			end else if (cmd.start_scan) begin
				ptr_q <= '0;
			end else if (cmd.issue_shift || cmd.issue_scan) begin
				ptr_q <= ptr_inc[CW-1:0];
			end
			if (cmd.load_req) begin
				pos_q <= '0;
			end else if (cmd.capture_pos) begin
				pos_q <= addr_s1;
			end
		end
	end

	assign status   = status_q;
	assign position = position_q;
	assign count    = count_q;

endmodule

@@ rtl/compacting_array_list_unit.sv @@
`timescale 1ns / 1ps
// Top level of the compacting array list: controller plus datapath.
// Depends on cal_pkg, cal_ctrl and cal_dp.
//
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   action, value, index
//  out      output     out_valid/out_stall status, position, count
//
// Insert, invalid-index remove and unused actions pass from accept through the execute state to the
// finish state, which loads the result and raises out_valid. Remove walks from index to the last entry
// and search from the first entry to the last or the first match; both walk the entry memory one entry per cycle.
// The controller returns to idle, and can take the next request, in the cycle after the result is loaded.
// Reset clears the count and control state; entry contents are left as they are.
// A new request is taken as soon as the controller is idle, even while a result
// waits under out_stall; the controller holds the next result until the output frees.
module compacting_array_list_unit
	import cal_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic [3:0]         index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [3:0]         position,
	output logic [4:0]         count
);

	localparam logic [4:0] CNT_FULL = 5'(CAPACITY % 32);

	cal_cmd_t cmd;
	cal_sts_t sts;

	// Sequencing of each request.
	cal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage, pointers and result registers.
	cal_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.action   (action),
		.value    (value),
		.index    (index),
		.cmd      (cmd),
		.sts      (sts),
		.status   (status),
		.position (position),
		.count    (count)
	);

`ifndef NO_ASSERTIONS
	// An accepted request raises in_stall in the cycle after its acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous one in progress");

	// A full report always comes with a count at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (count == CNT_FULL))
		else $error("full status with count below capacity");

	// A request with a status other than OK reports a zero position.
	a_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (position == 4'd0))
		else $error("nonzero position on failed request");
`endif

endmodule
